/* sv/dem_altitude_interpolate_smooth_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the elevation interpolation/smoothing unit
// Clocked property wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DEM_ALTITUDE_INTERPOLATE_SMOOTH_UNIT_ASSERT_SVH
`define DEM_ALTITUDE_INTERPOLATE_SMOOTH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define DAIS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// checked on every edge, reset included
`define DAIS_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DAIS_ASSERT(lbl, clk, rst, prop)
`define DAIS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

/* sv/dais_pkg.sv */
// ----------------------------------------------------------------------------
// dais_pkg
// Shared types and constants of the elevation interpolation/smoothing unit.
// ----------------------------------------------------------------------------
package dais_pkg;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_QUERY   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [15:0] VOID_MARK  = 16'd32768;
   localparam logic [16:0] BETA_ONE   = 17'd65536;
   localparam logic [16:0] BETA_RESET = 17'd19661;
   // ceil(2^25 / 3): exact quotient by 3 for dividends below 2^24
   localparam logic [23:0] RECIP3     = 24'd11184811;

   typedef struct packed {
      logic [1:0]  operation;
      logic [10:0] sample_row;
      logic [10:0] sample_column;
      logic [15:0] sample_value;
      logic [20:0] lat_position;
      logic [20:0] lon_position;
   } req_type;

   typedef struct packed {
      logic signed [20:0] altitude;
      logic [19:0]        interpolated_altitude;
      logic               void_unfilled;
   } rsp_type;

endpackage

/* sv/dem_altitude_interpolate_smooth_unit.sv */
// ----------------------------------------------------------------------------
// dem_altitude_interpolate_smooth_unit
// Elevation tile store with bilinear lookup and double exponential smoothing.
// ----------------------------------------------------------------------------
// Usage:
//  req_* : one transfer per command. Load writes one tile sample (ignored
//          when row or column is outside the tile), restart rearms the
//          smoother, query looks up the altitude at a position. Unused
//          operation codes are dropped.
//  rsp_* : one transfer per query: smoothed altitude, raw bilinear value
//          and a flag for a void corner that could not be filled.
//  csr_* : writes the smoothing weight; always ready, write only when idle.
// Sequence: a query walks its four corners through the single tile RAM port,
//  with in-tile neighbour reads for a void corner, then fill, weight and
//  accumulate steps; smoothing then runs through the shared 17x28
//  multiplier (skipped on the first query after reset or restart), and the
//  result is loaded into the output register.
// Throughput: one command at a time; no new command is taken until a query has loaded its result.
// Reset: smoother unarmed, weight back to its default; the tile keeps
//  whatever it holds and must be loaded before use (no clearing pass).
// Stall: the result register holds while rsp_ready is low; the next command
//  is still accepted, and a query finishing behind it waits.
// ----------------------------------------------------------------------------
`include "dem_altitude_interpolate_smooth_unit_assert.svh"

module dem_altitude_interpolate_smooth_unit #(
   parameter int TILE_SIDE              = 1201,
   parameter int POSITION_FRACTION_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dais_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dais_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [16:0]       csr_data
);

   localparam int CW  = $clog2(TILE_SIDE);            // grid coordinate
   localparam int AW  = $clog2(TILE_SIDE * TILE_SIDE);
   localparam int FB  = POSITION_FRACTION_BITS;
   localparam int FW  = FB + 1;                       // fraction 0..1.0
   localparam int WW  = 2 * FB + 1;                   // corner weight
   localparam int ACW = WW + 21;                      // weighted sum
   localparam longint unsigned POS_LIMIT = longint'(TILE_SIDE - 1) << FB;
   localparam logic [CW:0] LAST = (CW + 1)'(TILE_SIDE - 1);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'b0000_0000_0000_0001,
      ST_CENTER = 16'b0000_0000_0000_0010,
      ST_CHECK  = 16'b0000_0000_0000_0100,
      ST_NBRD   = 16'b0000_0000_0000_1000,
      ST_NBACC  = 16'b0000_0000_0001_0000,
      ST_FILL   = 16'b0000_0000_0010_0000,
      ST_WEIGHT = 16'b0000_0000_0100_0000,
      ST_MAC    = 16'b0000_0000_1000_0000,
      ST_SMX    = 16'b0000_0001_0000_0000,
      ST_S1A    = 16'b0000_0010_0000_0000,
      ST_S1B    = 16'b0000_0100_0000_0000,
      ST_S1C    = 16'b0000_1000_0000_0000,
      ST_S2A    = 16'b0001_0000_0000_0000,
      ST_S2B    = 16'b0010_0000_0000_0000,
      ST_S2C    = 16'b0100_0000_0000_0000,
      ST_OUT    = 16'b1000_0000_0000_0000
   } state_type;

   // cell index and fraction of a position, clamped to the last cell
   function automatic logic [CW+FW-1:0] split_pos(input logic [20:0] pos);
      longint unsigned p;
      longint unsigned c;
      longint unsigned f;
      p = longint'(pos);
      if (p > POS_LIMIT) begin
         p = POS_LIMIT;
      end
      c = p >> FB;
      if (c > longint'(TILE_SIDE - 2)) begin
         c = longint'(TILE_SIDE - 2);
      end
      f = p - (c << FB);
      return {CW'(c), FW'(f)};
   endfunction

   state_type          state_ff, state_in;
   logic [CW-1:0]      ci_ff, ci_in, cj_ff, cj_in;
   logic [FW-1:0]      p_ff, p_in, q_ff, q_in;
   logic [1:0]         corner_ff, corner_in;
   logic [1:0]         nb_k_ff, nb_k_in;
   logic [2:0]         nb_count_ff, nb_count_in;
   logic [17:0]        nb_sum_ff, nb_sum_in;
   logic [19:0]        cval_ff, cval_in;
   logic [WW-1:0]      w_ff, w_in;
   logic [ACW-1:0]     acc_ff, acc_in;
   logic               unfilled_ff, unfilled_in;
   logic [19:0]        x_ff, x_in;
   logic [27:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic               started_ff, started_in;
   logic [44:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic [16:0]        beta_reg_ff, beta_reg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dais_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               query_fire;
   logic               out_stalled;
   logic [CW+FW-1:0]   lat_split, lon_split;
   logic [CW:0]        cur_up, cur_east, nb_up, nb_east;
   logic               nb_inside;
   logic [CW:0]        rd_up, rd_east;
   logic [CW-1:0]      rd_row;
   logic [AW-1:0]      rd_addr, ld_addr, ram_addr;
   logic               ld_inside, ram_we;
   logic [15:0]        ram_rdata;
   logic [21:0]        fill_num;
   logic [45:0]        fill_div3;
   logic [19:0]        fill_val;
   logic [FW-1:0]      wa, wb;
   logic [ACW-1:0]     x_round;
   logic [27:0]        x8;
   logic [16:0]        beta, beta_inv, mul_a;
   logic [27:0]        mul_b;
   logic [44:0]        mul_p;
   logic [45:0]        blend;
   logic signed [30:0] diff;
   logic signed [22:0] alt_wide;
   logic signed [20:0] alt_sat;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign query_fire  = req_fire && (req_data.operation == dais_pkg::OP_QUERY);
   assign out_stalled = (state_ff == ST_OUT) && rsp_valid && !rsp_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   assign lat_split = split_pos(req_data.lat_position);
   assign lon_split = split_pos(req_data.lon_position);

   // corner grid position: bit 1 steps north, bit 0 steps east
   assign cur_up   = (CW + 1)'(ci_ff) + (CW + 1)'(corner_ff[1]);
   assign cur_east = (CW + 1)'(cj_ff) + (CW + 1)'(corner_ff[0]);

   // cross neighbour k: south, west, north, east
   always_comb begin
      nb_up     = cur_up;
      nb_east   = cur_east;
      nb_inside = 1'b0;
      case (nb_k_ff)
         2'd0: begin
            nb_up     = cur_up - 1'b1;
            nb_inside = (cur_up != '0);
         end
         2'd1: begin
            nb_east   = cur_east - 1'b1;
            nb_inside = (cur_east != '0);
         end
         2'd2: begin
            nb_up     = cur_up + 1'b1;
            nb_inside = (cur_up < LAST);
         end
         2'd3: begin
            nb_east   = cur_east + 1'b1;
            nb_inside = (cur_east < LAST);
         end
         default: begin
            nb_inside = 1'b0;
         end
      endcase
   end

   assign rd_up   = (state_ff == ST_NBRD) ? nb_up : cur_up;
   assign rd_east = (state_ff == ST_NBRD) ? nb_east : cur_east;
   assign rd_row  = CW'(LAST - rd_up);   // row 0 is the north edge
   assign rd_addr = AW'(rd_row) * AW'(TILE_SIDE) + AW'(rd_east);

   assign ld_inside = (32'(req_data.sample_row) < 32'(TILE_SIDE)) &&
                      (32'(req_data.sample_column) < 32'(TILE_SIDE));
   assign ld_addr   = AW'(req_data.sample_row) * AW'(TILE_SIDE) +
                      AW'(req_data.sample_column);
   assign ram_we    = req_fire && (req_data.operation == dais_pkg::OP_LOAD) && ld_inside;
   assign ram_addr  = (state_ff == ST_IDLE) ? ld_addr : rd_addr;

   dais_ram #(
      .WIDTH(16),
      .DEPTH(TILE_SIDE * TILE_SIDE)
   ) u_tile (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_data.sample_value),
      .rdata(ram_rdata)
   );

   // void fill: (16*sum + n/2) / n, n in 1..4
   assign fill_num  = {nb_sum_ff, 4'b0} + 22'(nb_count_ff >> 1);
   assign fill_div3 = 46'(fill_num) * 46'(dais_pkg::RECIP3);
   always_comb begin
      case (nb_count_ff)
         3'd1:    fill_val = fill_num[19:0];
         3'd2:    fill_val = fill_num[20:1];
         3'd3:    fill_val = fill_div3[44:25];
         3'd4:    fill_val = fill_num[21:2];
         default: fill_val = '0;
      endcase
   end

   assign wa      = corner_ff[1] ? p_ff : FW'((1 << FB)) - p_ff;
   assign wb      = corner_ff[0] ? q_ff : FW'((1 << FB)) - q_ff;
   assign x_round = acc_ff + (ACW'(1) << (2 * FB - 1));
   assign x8      = {x_ff[19:0], 8'b0};

   // shared smoothing multiplier
   assign beta     = (beta_reg_ff > dais_pkg::BETA_ONE) ? dais_pkg::BETA_ONE : beta_reg_ff;
   assign beta_inv = dais_pkg::BETA_ONE - beta;
   assign mul_a    = (state_ff == ST_S1A || state_ff == ST_S2A) ? beta : beta_inv;
   always_comb begin
      case (state_ff)
         ST_S1A:  mul_b = x8;
         ST_S1B:  mul_b = s1_ff;
         ST_S2A:  mul_b = s1_ff;
         default: mul_b = s2_ff;
      endcase
   end
   assign mul_p = 45'(mul_a) * 45'(mul_b);
   assign blend = 46'(pa_ff) + 46'(pb_ff) + 46'd32768;

   // 2*S1 - S2, /256 rounded half up, saturated
   assign diff     = $signed({2'b0, s1_ff, 1'b0}) - $signed({3'b0, s2_ff})
                     + 31'sd128;
   assign alt_wide = diff[30:8];
   always_comb begin
      if (alt_wide > 23'sd1048575) begin
         alt_sat = 21'sd1048575;
      end else if (alt_wide < -23'sd1048576) begin
         alt_sat = -21'sd1048576;
      end else begin
         alt_sat = alt_wide[20:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      corner_in    = corner_ff;
      nb_k_in      = nb_k_ff;
      nb_count_in  = nb_count_ff;
      nb_sum_in    = nb_sum_ff;
      cval_in      = cval_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      unfilled_in  = unfilled_ff;
      x_in         = x_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      started_in   = started_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      beta_reg_in  = csr_valid ? csr_data : beta_reg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               ci_in       = lat_split[CW+FW-1:FW];
               p_in        = lat_split[FW-1:0];
               cj_in       = lon_split[CW+FW-1:FW];
               q_in        = lon_split[FW-1:0];
               corner_in   = '0;
               acc_in      = '0;
               unfilled_in = 1'b0;
               state_in    = ST_CENTER;
            end else if (req_fire && req_data.operation == dais_pkg::OP_RESTART) begin
               started_in = 1'b0;
            end
         end
         ST_CENTER: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ram_rdata != dais_pkg::VOID_MARK) begin
               cval_in  = {ram_rdata, 4'b0};
               state_in = ST_WEIGHT;
            end else begin
               nb_k_in     = '0;
               nb_count_in = '0;
               nb_sum_in   = '0;
               state_in    = ST_NBRD;
            end
         end
         ST_NBRD: begin
            if (nb_inside) begin
               state_in = ST_NBACC;
            end else if (nb_k_ff == 2'd3) begin
               state_in = ST_FILL;
            end else begin
               nb_k_in = nb_k_ff + 1'b1;
            end
         end
         ST_NBACC: begin
            if (ram_rdata != dais_pkg::VOID_MARK) begin
               nb_sum_in   = nb_sum_ff + 18'(ram_rdata);
               nb_count_in = nb_count_ff + 1'b1;
            end
            if (nb_k_ff == 2'd3) begin
               state_in = ST_FILL;
            end else begin
               nb_k_in  = nb_k_ff + 1'b1;
               state_in = ST_NBRD;
            end
         end
         ST_FILL: begin
            cval_in = fill_val;
            if (nb_count_ff == '0) begin
               unfilled_in = 1'b1;
            end
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            w_in     = WW'(wa) * WW'(wb);
            state_in = ST_MAC;
         end
         ST_MAC: begin
            acc_in = acc_ff + ACW'(w_ff) * ACW'(cval_ff);
            if (corner_ff == 2'd3) begin
               state_in = ST_SMX;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in  = ST_CENTER;
            end
         end
         ST_SMX: begin
            x_in = x_round[2*FB +: 20];
            if (!started_ff) begin
               s1_in      = {x_round[2*FB +: 20], 8'b0};
               s2_in      = {x_round[2*FB +: 20], 8'b0};
               started_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_S1A;
            end
         end
         ST_S1A: begin
            pa_in    = mul_p;
            state_in = ST_S1B;
         end
         ST_S1B: begin
            pb_in    = mul_p;
            state_in = ST_S1C;
         end
         ST_S1C: begin
            s1_in    = blend[43:16];
            state_in = ST_S2A;
         end
         ST_S2A: begin
            pa_in    = mul_p;
            state_in = ST_S2B;
         end
         ST_S2B: begin
            pb_in    = mul_p;
            state_in = ST_S2C;
         end
         ST_S2C: begin
            s2_in    = blend[43:16];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                      = 1'b1;
               rsp_data_in.altitude              = alt_sat;
               rsp_data_in.interpolated_altitude = x_ff;
               rsp_data_in.void_unfilled         = unfilled_ff;
               state_in                          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         beta_reg_ff  <= dais_pkg::BETA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         beta_reg_ff  <= beta_reg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      corner_ff   <= corner_in;
      nb_k_ff     <= nb_k_in;
      nb_count_ff <= nb_count_in;
      nb_sum_ff   <= nb_sum_in;
      cval_ff     <= cval_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      unfilled_ff <= unfilled_in;
      x_ff        <= x_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      rsp_data_ff <= rsp_data_in;
   end

   `DAIS_ASSERT(a_query_starts_walk, clock, reset, query_fire |=> (state_ff == ST_CENTER))
   `DAIS_ASSERT(a_out_waits_for_slot, clock, reset, out_stalled |=> (state_ff == ST_OUT))
   `DAIS_ASSERT(a_fill_count_bound, clock, reset, (state_ff == ST_FILL) |-> (nb_count_ff <= 3'd4))
   `DAIS_ASSERT_NORST(a_reset_clears, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid))

endmodule

/* sv/dais_ram.sv */
// ----------------------------------------------------------------------------
// dais_ram
// Generic single-port RAM, one address per cycle, read on every cycle with an optional write, registered read.
// ----------------------------------------------------------------------------
module dais_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* sim/tb_dem_altitude_interpolate_smooth_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dem_altitude_interpolate_smooth_unit
// Self-checking bench for the elevation tile lookup with smoothing. Small
// patches of the tile are loaded around a chosen cell and queried at random
// fractions, with voids, edge cells and saturating positions mixed in. A
// scoreboard class predicts every query result and checks the rsp channel.
// ----------------------------------------------------------------------------
module tb_dem_altitude_interpolate_smooth_unit;

   localparam int SIDE     = 1201;
   localparam int FRAC     = 10;
   localparam int LAST_CELL = SIDE - 2;
   localparam int SETTLE   = 80;   // covers a four-void query plus smoothing

   // Predictor and store of pending query results.
   class altitude_scoreboard;
      bit [15:0]         tile_mem[int];
      logic [16:0]       weight;
      bit                armed;
      longint unsigned   first_s, second_s;
      dais_pkg::rsp_type pending_alt[$];
      int                mismatches;

      function new();
         weight = dais_pkg::BETA_RESET;
         armed = 0;
         first_s = 0;
         second_s = 0;
         mismatches = 0;
      endfunction

      function void set_weight(logic [16:0] w);
         weight = w;
      endfunction

      // tile sample at grid index counted north from the south edge
      function longint unsigned sample_at(int up, int east);
         return tile_mem[(SIDE - 1 - up) * SIDE + east];
      endfunction

      function longint unsigned corner(int up, int east, inout bit unf);
         longint unsigned v, sum, n, nb;
         v = sample_at(up, east);
         sum = 0;
         n = 0;
         if (v != dais_pkg::VOID_MARK) return v << 4;
         for (int k = 0; k < 4; k++) begin
            int u, e;
            u = up + (k == 0 ? -1 : k == 2 ? 1 : 0);
            e = east + (k == 1 ? -1 : k == 3 ? 1 : 0);
            if (u >= 0 && u < SIDE && e >= 0 && e < SIDE) begin
               nb = sample_at(u, e);
               if (nb != dais_pkg::VOID_MARK) begin
                  sum += nb;
                  n++;
               end
            end
         end
         if (n == 0) begin
            unf = 1;
            return 0;
         end
         return (sum * 16 + n / 2) / n;
      endfunction

      function void split(longint unsigned pos, output int cell_idx,
                          output longint unsigned fr);
         longint unsigned c;
         if (pos > (longint'(SIDE - 1) << FRAC)) pos = longint'(SIDE - 1) << FRAC;
         c = pos >> FRAC;
         if (c > LAST_CELL) c = LAST_CELL;
         cell_idx = int'(c);
         fr = pos - (c << FRAC);
      endfunction

      function void note_request(dais_pkg::req_type r);
         int i0, j0;
         longint unsigned p, q, pn, qn, acc, x, x8, beta;
         longint unsigned c00, c01, c10, c11;
         longint d, alt;
         bit unf;
         dais_pkg::rsp_type e;
         unf = 0;
         case (r.operation)
            dais_pkg::OP_LOAD: begin
               if (r.sample_row < SIDE && r.sample_column < SIDE)
                  tile_mem[r.sample_row * SIDE + r.sample_column] = r.sample_value;
            end
            dais_pkg::OP_RESTART: armed = 0;
            dais_pkg::OP_QUERY: begin
               split(r.lat_position, i0, p);
               split(r.lon_position, j0, q);
               pn = (1 << FRAC) - p;
               qn = (1 << FRAC) - q;
               c00 = corner(i0, j0, unf);
               c01 = corner(i0, j0 + 1, unf);
               c10 = corner(i0 + 1, j0, unf);
               c11 = corner(i0 + 1, j0 + 1, unf);
               acc = pn * qn * c00 + p * qn * c10 + pn * q * c01 + p * q * c11;
               x = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
               x8 = x << 8;
               beta = (weight > dais_pkg::BETA_ONE) ? dais_pkg::BETA_ONE : weight;
               if (!armed) begin
                  first_s = x8;
                  second_s = x8;
                  armed = 1;
               end else begin
                  first_s = (beta * x8 + (65536 - beta) * first_s + 32768) >> 16;
                  second_s = (beta * first_s + (65536 - beta) * second_s + 32768) >> 16;
               end
               d = 2 * longint'(first_s) - longint'(second_s) + 128;
               alt = d >>> 8;   // floor division by 256
               if (alt > 1048575) alt = 1048575;
               if (alt < -1048576) alt = -1048576;
               e.altitude = alt[20:0];
               e.interpolated_altitude = x[19:0];
               e.void_unfilled = unf;
               pending_alt.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_response(dais_pkg::rsp_type a);
         dais_pkg::rsp_type e;
         if (pending_alt.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: alt %0d interp %0d unfilled %0d",
                        a.altitude, a.interpolated_altitude, a.void_unfilled);
            return;
         end
         e = pending_alt.pop_front();
         if (a.altitude !== e.altitude
             || a.interpolated_altitude !== e.interpolated_altitude
             || a.void_unfilled !== e.void_unfilled) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                        e.altitude, e.interpolated_altitude, e.void_unfilled,
                        a.altitude, a.interpolated_altitude, a.void_unfilled);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   dais_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   dais_pkg::rsp_type rsp_data;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [16:0]       csr_data = '0;

   altitude_scoreboard sb = new();

   int send_idle_pct = 26;
   int recv_idle_pct = 74;
   logic hold_request = 0;
   logic hold_taken = 0;
   int   hold_left = 0;

   dem_altitude_interpolate_smooth_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Receiver: random stalls, plus one long hold-off counted here so the
   // block backs up and stalls its req side.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1;
         hold_left <= 400;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every accepted rsp transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // One req transfer; idle cycles ahead of it are drawn one at a time.
   // The item is noted when it is accepted.
   task automatic send_item(dais_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic send_load(int row, int col, logic [15:0] value);
      dais_pkg::req_type r;
      r = '0;
      r.operation = dais_pkg::OP_LOAD;
      r.sample_row = row[10:0];
      r.sample_column = col[10:0];
      r.sample_value = value;
      r.lat_position = 21'($urandom());
      r.lon_position = 21'($urandom());
      send_item(r);
   endtask

   task automatic send_query(logic [20:0] lat, logic [20:0] lon);
      dais_pkg::req_type r;
      r = '0;
      r.operation = dais_pkg::OP_QUERY;
      r.sample_row = 11'($urandom());
      r.sample_column = 11'($urandom());
      r.sample_value = 16'($urandom());
      r.lat_position = lat;
      r.lon_position = lon;
      send_item(r);
   endtask

   task automatic send_other(logic [1:0] op);
      dais_pkg::req_type r;
      r = '0;
      r.operation = op;
      r.sample_row = 11'($urandom());
      r.sample_column = 11'($urandom());
      r.sample_value = 16'($urandom());
      r.lat_position = 21'($urandom());
      r.lon_position = 21'($urandom());
      send_item(r);
   endtask

   // Load the 4x4 grid around cell (a, b), clipped to the tile, so every
   // corner and every neighbor a void fill may read is written.
   // style: 0 mixed with voids, 1 all void, 2 heights above the marker mixed with voids
   task automatic load_patch(int a, int b, int style, inout int count);
      logic [15:0] v;
      for (int du = -1; du <= 2; du++) begin
         for (int de = -1; de <= 2; de++) begin
            if (a + du >= 0 && a + du < SIDE && b + de >= 0 && b + de < SIDE) begin
               if (style == 1 || $urandom_range(0, 99) < 15) v = dais_pkg::VOID_MARK;
               else if (style == 2) v = 16'($urandom_range(32769, 65535));
               else v = 16'($urandom());
               send_load(SIDE - 1 - (a + du), b + de, v);
               count++;
            end
         end
      end
   endtask

   function automatic logic [20:0] pos_in_cell(int c);
      if (c == LAST_CELL && $urandom_range(0, 2) == 0)
         return 21'($urandom_range(LAST_CELL * 1024, 2097151));   // saturating
      return 21'(c * 1024 + $urandom_range(0, 1023));
   endfunction

   function automatic int pick_cell();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return LAST_CELL;
         default: return $urandom_range(0, LAST_CELL);
      endcase
   endfunction

   task automatic run_random(int n);
      int count, a, b, nq, style;
      count = 0;
      while (count < n) begin
         a = pick_cell();
         b = pick_cell();
         style = $urandom_range(0, 9);
         style = (style == 0) ? 1 : (style == 1) ? 2 : 0;
         load_patch(a, b, style, count);
         nq = $urandom_range(2, 6);
         for (int k = 0; k < nq; k++) begin
            case ($urandom_range(0, 19))
               0, 1: send_other(dais_pkg::OP_RESTART);
               2: send_other(dais_pkg::OP_UNUSED);
               3: send_load($urandom_range(SIDE, 2047), $urandom(), 16'($urandom()));
               default: ;
            endcase
            send_query(pos_in_cell(a), pos_in_cell(b));
            count += 2;
         end
      end
   endtask

   // Settle, then write the weight while the block is idle.
   task automatic write_weight(logic [16:0] w);
      req_valid <= 0;
      while (sb.pending_alt.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_weight(w);
   endtask

   initial begin
      int n;
      n = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: tile corner cells, voids, max positions, restart, op 3.
      load_patch(0, 0, 0, n);
      send_query(21'd0, 21'd0);
      send_query(21'd1023, 21'd1023);
      send_other(dais_pkg::OP_UNUSED);
      send_load(2047, 2047, 16'hFFFF);     // off the tile: dropped
      send_other(dais_pkg::OP_RESTART);
      send_query(21'd512, 21'd0);
      load_patch(LAST_CELL, LAST_CELL, 1, n);   // all void: unfilled flag
      send_query(21'h1FFFFF, 21'h1FFFFF);
      send_query(21'(LAST_CELL * 1024), 21'd1228799);

      write_weight(17'd0);
      run_random(280);

      write_weight(17'h1FFFF);             // above one acts as one
      send_idle_pct = 74;
      recv_idle_pct = 26;
      run_random(280);

      write_weight(dais_pkg::BETA_ONE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request <= 1;
      run_random(140);

      write_weight(17'($urandom_range(1, 65535)));
      run_random(140);

      req_valid <= 0;
      while (sb.pending_alt.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_alt.size() == 0)
         $display("tb_dem_altitude_interpolate_smooth_unit: clean");
      else
         $display("tb_dem_altitude_interpolate_smooth_unit: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_dem_altitude_interpolate_smooth_unit: errors");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/dais_pkg.sv
sv/dais_ram.sv
sv/dem_altitude_interpolate_smooth_unit.sv
sim/tb_dem_altitude_interpolate_smooth_unit.sv
